@@ rtl/rcd_pkg.sv @@
// Rod cutting DP package: sizes and widths shared by the top level and checker.
// No dependencies.
package rcd_pkg;

  localparam int MAX_LEN = 64;
  localparam int PRICE_W = 16;
  localparam int REV_W   = 22;
  localparam int LEN_W   = 7;
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int ENTRY_W = REV_W + LEN_W;

  localparam logic [REV_W-1:0] REV_MAX = {REV_W{1'b1}};

endpackage

@@ rtl/rcd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/rod_cutting_dp.sv @@
// Rod cutting DP top level: price load, revenue table fill, result readout.
// Depends on rcd_pkg and rcd_ram.
// Load: one price per cycle while busy is low. On the last price the block goes busy,
// fills each length j with one price/revenue RAM read pair per cut, then emits
// L results on consecutive cycles, not stallable.
// Reset clears the control state and load count; RAM contents are not cleared.
module rod_cutting_dp
  import rcd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [PRICE_W-1:0] price_i,
  input  logic               last_price_i,
  output logic               strobe_o,
  output logic [LEN_W-1:0]   rod_length_o,
  output logic [REV_W-1:0]   best_revenue_o,
  output logic [LEN_W-1:0]   first_cut_o,
  output logic               final_result_o
);

  localparam logic [1:0] S_LOAD = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, len_q, len_d, i_q, i_d, j_q, j_d;
  logic [CNT_W-1:0] rd_i_q, rd_i_d;
  logic             rd_vld_q, rd_vld_d, rd_zero_q, rd_zero_d;
  logic [REV_W-1:0] best_q, best_d;
  logic [LEN_W-1:0] cut_q, cut_d;
  logic             out_vld_q, out_vld_d, out_fin_q, out_fin_d;
  logic [LEN_W-1:0] out_len_q, out_len_d;

  logic               pr_we;
  logic [ADDR_W-1:0]  pr_raddr;
  logic [PRICE_W-1:0] pr_rdata;
  logic               rv_we;
  logic [ADDR_W-1:0]  rv_raddr;
  logic [ENTRY_W-1:0] rv_wdata, rv_rdata;

  logic [REV_W:0]     sum;
  logic [REV_W-1:0]   cand, best_new;
  logic [LEN_W-1:0]   cut_new;
  logic               take;

  assign pr_we = (state_q == S_LOAD) && start && (cnt_q < CNT_W'(MAX_LEN));

  rcd_ram #(.WIDTH(PRICE_W), .DEPTH(MAX_LEN)) u_price_ram (
    .clk_i   (clk_i),
    .we_i    (pr_we),
    .waddr_i (cnt_q[ADDR_W-1:0]),
    .wdata_i (price_i),
    .raddr_i (pr_raddr),
    .rdata_o (pr_rdata)
  );

  // entry j-1 holds {cut[j], best[j]}; best[0] is forced to zero on read
  rcd_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_LEN)) u_rev_ram (
    .clk_i   (clk_i),
    .we_i    (rv_we),
    .waddr_i (ADDR_W'(j_q - CNT_W'(1))),
    .wdata_i (rv_wdata),
    .raddr_i (rv_raddr),
    .rdata_o (rv_rdata)
  );

  assign pr_raddr = ADDR_W'(i_q - CNT_W'(1));
  assign rv_raddr = (state_q == S_OUT) ? ADDR_W'(j_q - CNT_W'(1))
                                       : ADDR_W'(j_q - i_q - CNT_W'(1));

  assign sum      = (REV_W+1)'(pr_rdata) +
                    {1'b0, (rd_zero_q ? {REV_W{1'b0}} : rv_rdata[REV_W-1:0])};
  assign cand     = sum[REV_W] ? REV_MAX : sum[REV_W-1:0];
  assign take     = rd_vld_q && (cand > best_q);
  assign best_new = take ? cand : best_q;
  assign cut_new  = take ? LEN_W'(rd_i_q) : cut_q;

  assign rv_we    = (state_q == S_FIN);
  assign rv_wdata = {cut_new, best_new};

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    len_d     = len_q;
    i_d       = i_q;
    j_d       = j_q;
    rd_vld_d  = 1'b0;
    rd_i_d    = i_q;
    rd_zero_d = (i_q == j_q);
    best_d    = best_new;
    cut_d     = cut_new;
    out_vld_d = 1'b0;
    out_len_d = LEN_W'(j_q);
    out_fin_d = (j_q == len_q);
    case (state_q)
      S_LOAD: begin
        if (start) begin
          if (pr_we) begin
            cnt_d = cnt_q + CNT_W'(1);
          end
          if (last_price_i) begin
            len_d   = pr_we ? cnt_q + CNT_W'(1) : cnt_q;
            cnt_d   = '0;
            i_d     = CNT_W'(1);
            j_d     = CNT_W'(1);
            best_d  = '0;
            cut_d   = LEN_W'(1);
            state_d = S_CALC;
          end
        end
      end
      S_CALC: begin
        rd_vld_d = 1'b1;
        if (i_q == j_q) begin
          state_d = S_FIN;
        end else begin
          i_d = i_q + CNT_W'(1);
        end
      end
      S_FIN: begin
        best_d = '0;
        cut_d  = LEN_W'(1);
        i_d    = CNT_W'(1);
        if (j_q == len_q) begin
          j_d     = CNT_W'(1);
          state_d = S_OUT;
        end else begin
          j_d     = j_q + CNT_W'(1);
          state_d = S_CALC;
        end
      end
      S_OUT: begin
        out_vld_d = 1'b1;
        if (j_q == len_q) begin
          state_d = S_LOAD;
        end else begin
          j_d = j_q + CNT_W'(1);
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      cnt_q     <= '0;
      len_q     <= '0;
      i_q       <= '0;
      j_q       <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      len_q     <= len_d;
      i_q       <= i_d;
      j_q       <= j_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_i_q    <= rd_i_d;
    rd_zero_q <= rd_zero_d;
    best_q    <= best_d;
    cut_q     <= cut_d;
    out_len_q <= out_len_d;
    out_fin_q <= out_fin_d;
  end

  assign busy           = (state_q != S_LOAD);
  assign strobe_o       = out_vld_q;
  assign rod_length_o   = out_len_q;
  assign best_revenue_o = rv_rdata[REV_W-1:0];
  assign first_cut_o    = rv_rdata[ENTRY_W-1:REV_W];
  assign final_result_o = out_fin_q;

endmodule

@@ rtl/rcd_checker.sv @@
// Port-level checker for rod_cutting_dp, bound to the top level.
// Depends on rcd_pkg.
module rcd_checker
  import rcd_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic [PRICE_W-1:0] price_i,
  input logic               last_price_i,
  input logic               strobe_o,
  input logic [LEN_W-1:0]   rod_length_o,
  input logic [REV_W-1:0]   best_revenue_o,
  input logic [LEN_W-1:0]   first_cut_o,
  input logic               final_result_o
);

  a_go_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && last_price_i |=> busy)
    else $error("last price did not start the fill");

  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !final_result_o |=>
      strobe_o && (rod_length_o == LEN_W'($past(rod_length_o) + LEN_W'(1))))
    else $error("result burst broken or lengths out of order");

  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && final_result_o |=> !strobe_o)
    else $error("result after the final one");

  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !final_result_o |-> busy)
    else $error("result while idle");

  a_cut: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (first_cut_o != '0) && (first_cut_o <= rod_length_o))
    else $error("first cut out of range");

endmodule

bind rod_cutting_dp rcd_checker u_rcd_checker (.*);
